/* rtl/tts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tts_pkg
// shared types, constants and byte classification for the tokenizer core
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int MAX_WORD_DEF = 32;
  localparam int STOP_COUNT   = 110;
  localparam int STOP_LEN     = 7;

  typedef logic [STOP_LEN*8-1:0] stop_word_t;

  // one closed token handed from front to back
  // head holds the first bytes, tail the last three with the last byte low
  typedef struct packed {
    stop_word_t  head;
    logic [23:0] tail;
    logic [5:0]  len;
    logic        trunc;
    logic        eot;
    logic        bank;
  } tok_desc_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CHECK,
    BK_EMIT,
    BK_MARK
  } bk_state_t;

  function automatic logic is_space(input logic [7:0] b);
    return ((b >= 8'h09) && (b <= 8'h0d)) || (b == 8'h20);
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    case (b)
      8'h2e, 8'h2c, 8'h3f, 8'h21, 8'h3b, 8'h3a, 8'h27, 8'h22,
      8'h28, 8'h29, 8'h5b, 8'h5d, 8'h7b, 8'h7d, 8'h2d, 8'he2: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5a)) ? (b + 8'd32) : b;
  endfunction

  // first character in the low byte, zero padded
  function automatic stop_word_t pk(input string s);
    stop_word_t w;
    w = '0;
    for (int i = 0; i < s.len(); i++) w[i*8 +: 8] = s[i];
    return w;
  endfunction

  function automatic stop_word_t stop_entry(input logic [6:0] k);
    case (k)
      7'd0: return pk("a");       7'd1: return pk("an");
      7'd2: return pk("and");     7'd3: return pk("the");
      7'd4: return pk("or");      7'd5: return pk("of");
      7'd6: return pk("to");      7'd7: return pk("in");
      7'd8: return pk("for");     7'd9: return pk("on");
      7'd10: return pk("with");   7'd11: return pk("at");
      7'd12: return pk("by");     7'd13: return pk("i");
      7'd14: return pk("you");    7'd15: return pk("he");
      7'd16: return pk("she");    7'd17: return pk("it");
      7'd18: return pk("we");     7'd19: return pk("they");
      7'd20: return pk("me");     7'd21: return pk("him");
      7'd22: return pk("her");    7'd23: return pk("us");
      7'd24: return pk("them");   7'd25: return pk("my");
      7'd26: return pk("your");   7'd27: return pk("his");
      7'd28: return pk("its");    7'd29: return pk("our");
      7'd30: return pk("their");  7'd31: return pk("this");
      7'd32: return pk("that");   7'd33: return pk("these");
      7'd34: return pk("those");  7'd35: return pk("is");
      7'd36: return pk("are");    7'd37: return pk("was");
      7'd38: return pk("were");   7'd39: return pk("be");
      7'd40: return pk("been");   7'd41: return pk("being");
      7'd42: return pk("have");   7'd43: return pk("has");
      7'd44: return pk("had");    7'd45: return pk("do");
      7'd46: return pk("does");   7'd47: return pk("did");
      7'd48: return pk("will");   7'd49: return pk("would");
      7'd50: return pk("shall");  7'd51: return pk("should");
      7'd52: return pk("may");    7'd53: return pk("might");
      7'd54: return pk("must");   7'd55: return pk("can");
      7'd56: return pk("could");  7'd57: return pk("as");
      7'd58: return pk("but");    7'd59: return pk("if");
      7'd60: return pk("because"); 7'd61: return pk("until");
      7'd62: return pk("while");  7'd63: return pk("about");
      7'd64: return pk("against"); 7'd65: return pk("between");
      7'd66: return pk("into");   7'd67: return pk("through");
      7'd68: return pk("during"); 7'd69: return pk("before");
      7'd70: return pk("after");  7'd71: return pk("above");
      7'd72: return pk("below");  7'd73: return pk("from");
      7'd74: return pk("up");     7'd75: return pk("down");
      7'd76: return pk("out");    7'd77: return pk("off");
      7'd78: return pk("over");   7'd79: return pk("under");
      7'd80: return pk("again");  7'd81: return pk("further");
      7'd82: return pk("then");   7'd83: return pk("once");
      7'd84: return pk("here");   7'd85: return pk("there");
      7'd86: return pk("when");   7'd87: return pk("where");
      7'd88: return pk("why");    7'd89: return pk("how");
      7'd90: return pk("all");    7'd91: return pk("any");
      7'd92: return pk("both");   7'd93: return pk("each");
      7'd94: return pk("few");    7'd95: return pk("more");
      7'd96: return pk("most");   7'd97: return pk("other");
      7'd98: return pk("some");   7'd99: return pk("such");
      7'd100: return pk("no");    7'd101: return pk("nor");
      7'd102: return pk("not");   7'd103: return pk("only");
      7'd104: return pk("own");   7'd105: return pk("same");
      7'd106: return pk("so");    7'd107: return pk("than");
      7'd108: return pk("too");   7'd109: return pk("very");
      default: return '1;
    endcase
  endfunction

  // stop words are 1..7 chars; a match needs equal length and equal bytes
  function automatic logic stop_match(input logic [5:0] len, input stop_word_t head);
    stop_word_t e;
    logic [3:0] n;
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < STOP_COUNT; k++) begin
      e = stop_entry(7'(k));
      n = 4'd0;
      for (int j = 0; j < STOP_LEN; j++) if (e[j*8 +: 8] != 8'h00) n = 4'(j + 1);
      if ((len == {2'b00, n}) && (e != '1)) begin
        if (((head ^ e) & ((stop_word_t'(1) << (n * 8)) - 1'b1)) == '0) hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

/* rtl/tts_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tts_front
// classifies bytes, writes them to a two bank token store, posts descriptors
// ----------------------------------------------------------------------------
module tts_front #(
  parameter int MAX_WORD = tts_pkg::MAX_WORD_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_end_of_text,
  output logic                    wr_en,
  output logic                    wr_bank,
  output logic [5:0]              wr_addr,
  output logic [7:0]              wr_data,
  output logic                    q_push,
  output tts_pkg::tok_desc_t      q_desc,
  input  wire logic               q_full,
  input  wire logic               bank_busy
) ;

  logic [5:0] len_r, len_nxt;
  logic       ovf_r, ovf_nxt;
  logic       bank_r, bank_nxt;
  tts_pkg::stop_word_t head_r, head_nxt;
  logic [23:0] tail_r, tail_nxt;
  logic [7:0] b;
  logic       sp, keep, flush, acc;

  // hold off while the back end owns a bank or the queue has no slot
  assign in_stall = q_full || bank_busy;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    b     = tts_pkg::to_lower(in_data_byte);
    sp    = tts_pkg::is_space(in_data_byte);
    keep  = !sp && !tts_pkg::is_punct(b);
    flush = sp || in_end_of_text;
    wr_en   = acc && keep && (len_r < 6'(MAX_WORD));
    wr_bank = bank_r;
    wr_addr = len_r;
    wr_data = b;
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    bank_nxt = bank_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    q_push  = 1'b0;
    q_desc  = '0;
    if (acc) begin
      if (wr_en) begin
        len_nxt = len_r + 6'd1;
        // first bytes for the stop word check, last three for the suffix
        for (int j = 0; j < tts_pkg::STOP_LEN; j++)
          if (len_r == 6'(j)) head_nxt[j*8 +: 8] = b;
        tail_nxt = {tail_r[15:0], b};
      end else if (keep) ovf_nxt = 1'b1;
      if (flush) begin
        q_desc.head  = head_nxt;
        q_desc.tail  = tail_nxt;
        q_desc.len   = len_nxt;
        q_desc.trunc = ovf_nxt;
        q_desc.eot   = in_end_of_text;
        q_desc.bank  = bank_r;
        // empty token without end of text yields nothing
        q_push   = (len_nxt != 6'd0) || in_end_of_text;
        if (len_nxt != 6'd0) bank_nxt = !bank_r;
        len_nxt  = 6'd0;
        ovf_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0; ovf_r <= 1'b0; bank_r <= 1'b0; head_r <= '0; tail_r <= '0;
    end else begin
      len_r <= len_nxt; ovf_r <= ovf_nxt; bank_r <= bank_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/tts_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tts_queue
// two entry descriptor queue between front and back
// ----------------------------------------------------------------------------
module tts_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  tts_pkg::tok_desc_t      din,
  output logic                    full,
  input  wire logic               pop,
  output logic                    nonempty,
  output tts_pkg::tok_desc_t      dout
);

  tts_pkg::tok_desc_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = cnt_r == 2'd2;
  assign nonempty = cnt_r != 2'd0;
  assign dout     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/tts_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tts_back
// stop word check, suffix stem and byte emission from the token store
// ----------------------------------------------------------------------------
module tts_back #(
  parameter int MAX_WORD = tts_pkg::MAX_WORD_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire logic               wr_bank,
  input  wire logic [5:0]         wr_addr,
  input  wire logic [7:0]         wr_data,
  input  wire logic               q_nonempty,
  input  tts_pkg::tok_desc_t      q_desc,
  output logic                    q_pop,
  output logic                    bank_busy,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_out_byte,
  output logic                    out_has_byte,
  output logic                    out_token_last,
  output logic                    out_truncated,
  output logic                    out_text_end
);

  localparam int AW = $clog2(MAX_WORD);

  // two bank token store, one registered read per cycle
  logic [7:0] buf_r [2][MAX_WORD];
  logic [7:0] rd_r;

  tts_pkg::bk_state_t st_r, st_nxt;
  tts_pkg::tok_desc_t cur_r, cur_nxt;
  logic [5:0] n_r, n_nxt, i_r, i_nxt;
  logic       stop_r, stop_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       oh_r, oh_nxt, ol_r, ol_nxt, ot_r, ot_nxt, oe_r, oe_nxt;
  logic       busy_r, busy_nxt;

  logic [7:0] c1, c2, c3;
  logic [5:0] n_stem;
  logic       can_load;

  // the read address follows the next index, so rd_r holds byte i_r
  always_ff @(posedge clk) begin
    if (wr_en) buf_r[wr_bank][wr_addr[AW-1:0]] <= wr_data;
    rd_r <= buf_r[cur_r.bank][i_nxt[AW-1:0]];
  end

  always_comb begin
    c1 = cur_r.tail[7:0];
    c2 = cur_r.tail[15:8];
    c3 = cur_r.tail[23:16];
    n_stem = cur_r.len;
    if (cur_r.len > 6'd4) begin
      if (c3 == "i" && c2 == "n" && c1 == "g") n_stem = cur_r.len - 6'd3;
      else if ((c2 == "l" && c1 == "y") || (c2 == "e" && c1 == "d") ||
               (c2 == "e" && c1 == "s")) n_stem = cur_r.len - 6'd2;
      else if (c1 == "s") n_stem = cur_r.len - 6'd1;
    end
  end

  assign out_valid      = ov_r;
  assign out_out_byte   = ob_r;
  assign out_has_byte   = oh_r;
  assign out_token_last = ol_r;
  assign out_truncated  = ot_r;
  assign out_text_end   = oe_r;
  // the bank under processing stays locked until its bytes are out
  assign bank_busy = busy_r;

  always_comb begin
    st_nxt = st_r; cur_nxt = cur_r; n_nxt = n_r; i_nxt = i_r; stop_nxt = stop_r;
    ov_nxt = ov_r && out_stall;
    ob_nxt = ob_r; oh_nxt = oh_r; ol_nxt = ol_r; ot_nxt = ot_r; oe_nxt = oe_r;
    busy_nxt = busy_r;
    q_pop = 1'b0;
    can_load = !ov_r || !out_stall;
    case (st_r)
      tts_pkg::BK_IDLE: begin
        if (q_nonempty) begin
          q_pop = 1'b1;
          cur_nxt = q_desc;
          busy_nxt = q_desc.len != 6'd0;
          st_nxt = (q_desc.len != 6'd0) ? tts_pkg::BK_CHECK : tts_pkg::BK_MARK;
        end
      end
      tts_pkg::BK_CHECK: begin
        stop_nxt = tts_pkg::stop_match(cur_r.len, cur_r.head);
        n_nxt = n_stem;
        i_nxt = '0;
        st_nxt = tts_pkg::BK_EMIT;
      end
      tts_pkg::BK_EMIT: begin
        if (stop_r) begin
          busy_nxt = 1'b0;
          st_nxt = cur_r.eot ? tts_pkg::BK_MARK : tts_pkg::BK_IDLE;
        end else if (can_load) begin
          ov_nxt = 1'b1;
          ob_nxt = rd_r;
          oh_nxt = 1'b1;
          ol_nxt = (i_r + 6'd1) == n_r;
          ot_nxt = cur_r.trunc;
          oe_nxt = 1'b0;
          i_nxt = i_r + 6'd1;
          if ((i_r + 6'd1) == n_r) begin
            busy_nxt = 1'b0;
            st_nxt = cur_r.eot ? tts_pkg::BK_MARK : tts_pkg::BK_IDLE;
          end
        end
      end
      tts_pkg::BK_MARK: begin
        if (can_load) begin
          ov_nxt = 1'b1;
          ob_nxt = 8'h00; oh_nxt = 1'b0; ol_nxt = 1'b0; ot_nxt = 1'b0; oe_nxt = 1'b1;
          st_nxt = tts_pkg::BK_IDLE;
        end
      end
      default: st_nxt = tts_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tts_pkg::BK_IDLE; ov_r <= 1'b0; busy_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; n_r <= n_nxt; i_r <= i_nxt; stop_r <= stop_nxt;
    ob_r <= ob_nxt; oh_r <= oh_nxt; ol_r <= ol_nxt; ot_r <= ot_nxt; oe_r <= oe_nxt;
  end

  a_mark_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oe_r |-> !oh_r && !ol_r && !ot_r) else $error("marker carries byte");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_stall |=> ov_r && $stable(ob_r) && $stable(oe_r))
    else $error("result changed under stall");
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == tts_pkg::BK_EMIT && !stop_r |-> busy_r) else $error("bank not locked");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == tts_pkg::BK_EMIT && !stop_r |-> i_r < n_r) else $error("index past end");

endmodule
`default_nettype wire

/* rtl/text_tokenizer_stopword_stemmer_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_tokenizer_stopword_stemmer_core
// byte stream tokenizer with stop word filter and suffix stemmer
// ----------------------------------------------------------------------------
// Ordinary bytes are taken one per cycle while the back end is idle. A byte
// that closes a token posts it through a two entry queue; an idle back end pops
// it in the next cycle, spends the CHECK state on the stop word and suffix
// check and then emits one token byte per cycle through a registered output
// while the output is not stalled. The front takes at most one more byte in
// the cycle of the pop and then stalls while the back end holds the token. The
// end of text marker costs one more back end state, MARK, but no input stall,
// so byte emission is what sets the sustained rate.
module text_tokenizer_stopword_stemmer_core #(
  parameter int MAX_WORD = tts_pkg::MAX_WORD_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_out_byte,
  output logic            out_has_byte,
  output logic            out_token_last,
  output logic            out_truncated,
  output logic            out_text_end
);

  logic wr_en, wr_bank, q_push, q_full, q_pop, q_ne, bank_busy;
  logic [5:0] wr_addr;
  logic [7:0] wr_data;
  tts_pkg::tok_desc_t q_din, q_dout;

  tts_front #(.MAX_WORD(MAX_WORD)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_byte, .in_end_of_text,
    .wr_en, .wr_bank, .wr_addr, .wr_data, .q_push, .q_desc(q_din), .q_full,
    .bank_busy
  );

  tts_queue u_queue (
    .clk, .rst_n, .push(q_push), .din(q_din), .full(q_full), .pop(q_pop),
    .nonempty(q_ne), .dout(q_dout)
  );

  tts_back #(.MAX_WORD(MAX_WORD)) u_back (
    .clk, .rst_n, .wr_en, .wr_bank, .wr_addr, .wr_data, .q_nonempty(q_ne),
    .q_desc(q_dout), .q_pop, .bank_busy, .out_valid, .out_stall, .out_out_byte,
    .out_has_byte, .out_token_last, .out_truncated, .out_text_end
  );

endmodule
`default_nettype wire
